### design/pal_pkg.sv
// pal_pkg: shared types and codes for the positional array list.
// Request and result records, opcodes, status codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package pal_pkg;

  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  item_value;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  found_position;
    logic [VAL_W-1:0]  result_value;
    logic [POS_W-1:0]  list_length;
    logic              last;
  } result_t;

endpackage

### design/pal_front.sv
// pal_front: request intake for the positional array list.
// Accepts input beats, classifies the opcode and buffers two requests.
// Depends on pal_pkg.
`timescale 1ns / 1ps

module pal_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_opcode,
  input  logic [4:0]    in_position,
  input  logic [31:0]   in_item_value,
  output logic          req_valid,
  input  logic          req_ready,
  output pal_pkg::req_t req
);

  pal_pkg::req_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    level_r, level_nxt;
  logic          push, pop;
  pal_pkg::req_t in_req;

  // opcode 3 is kept as its own class; the back end reports it as a bad request
  always_comb begin
    in_req.op         = pal_pkg::op_t'(in_opcode);
    in_req.position   = in_position;
    in_req.item_value = in_item_value;
  end

  assign in_ready  = (level_r != 2'd2);
  assign req_valid = (level_r != 2'd0);
  assign req       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = req_valid && req_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    level_nxt  = level_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_req;
    end
  end

endmodule

### design/pal_back.sv
// pal_back: list store and execution sequencer for the positional array list.
// Holds the entry row and count, runs insert/delete/locate, drives the result register.
// Depends on pal_pkg.
`timescale 1ns / 1ps

module pal_back #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [4:0]       limit,
  input  logic             req_valid,
  output logic             req_ready,
  input  pal_pkg::req_t    req,
  output logic             out_valid,
  input  logic             out_ready,
  output pal_pkg::result_t out_res
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMPW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

  logic [31:0]         entries_r   [CAPACITY];
  logic [31:0]         entries_nxt [CAPACITY];
  logic [CW-1:0]       count_r, count_nxt;
  logic [CAPACITY-1:0] mask_r, mask_nxt;
  logic [31:0]         key_r, key_nxt;
  logic                out_valid_r, out_valid_nxt;
  pal_pkg::result_t    out_res_r, out_res_nxt;
  pal_pkg::state_t     state_r, state_nxt;

  logic                out_free;
  logic                accept;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] mask_rest;
  logic [IW-1:0]       first_idx;
  logic [CMPW-1:0]     pos_x, cnt_x, lim_x, p_x, cnt_after;
  logic                ins_bad, ins_full, del_bad;

  assign out_free  = !out_valid_r || out_ready;
  assign req_ready = (state_r == pal_pkg::S_IDLE) && out_free;
  assign accept    = req_valid && req_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign pos_x = CMPW'(req.position);
  assign cnt_x = CMPW'(count_r);
  assign lim_x = CMPW'(limit);
  assign p_x   = pos_x - CMPW'(1);

  assign ins_bad  = (req.position == '0) || (pos_x > cnt_x + CMPW'(1));
  assign ins_full = (cnt_x >= lim_x) || (count_r >= CW'(CAPACITY));
  assign del_bad  = (req.position == '0) || (pos_x > cnt_x);

  // all compares in parallel against the stored row
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < count_r) && (entries_r[i] == req.item_value);
    end
  end

  // lowest pending match
  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        first_idx = IW'(i);
      end
    end
  end

  assign mask_rest = mask_r & (mask_r - CAPACITY'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pal_pkg::S_IDLE: begin
        if (accept && (req.op == pal_pkg::OP_LOCATE) && (match != '0)) begin
          state_nxt = pal_pkg::S_SCAN;
        end
      end
      pal_pkg::S_SCAN: begin
        if (out_free && (mask_rest == '0)) begin
          state_nxt = pal_pkg::S_IDLE;
        end
      end
      default: state_nxt = pal_pkg::S_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    count_nxt     = count_r;
    mask_nxt      = mask_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    cnt_after     = cnt_x;

    if (accept) begin
      out_res_nxt.status         = pal_pkg::ST_BAD_POS;
      out_res_nxt.found_position = '0;
      out_res_nxt.result_value   = '0;
      out_res_nxt.last           = 1'b1;
      out_valid_nxt              = 1'b1;
      case (req.op)
        pal_pkg::OP_INSERT: begin
          if (!ins_bad) begin
            if (ins_full) begin
              out_res_nxt.status = pal_pkg::ST_FULL;
            end else begin
              for (int i = 0; i < CAPACITY; i++) begin
                if (CMPW'(i) == p_x) begin
                  entries_nxt[i] = req.item_value;
                end else if (CMPW'(i) > p_x) begin
                  entries_nxt[i] = entries_r[(i > 0) ? i - 1 : 0];
                end
              end
              cnt_after          = cnt_x + CMPW'(1);
              count_nxt          = count_r + CW'(1);
              out_res_nxt.status = pal_pkg::ST_OK;
            end
          end
        end
        pal_pkg::OP_DELETE: begin
          if (!del_bad) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (CMPW'(i) >= p_x) begin
                entries_nxt[i] = entries_r[(i < CAPACITY - 1) ? i + 1 : i];
              end
            end
            cnt_after                = cnt_x - CMPW'(1);
            count_nxt                = count_r - CW'(1);
            out_res_nxt.status       = pal_pkg::ST_OK;
            out_res_nxt.result_value = entries_r[p_x[IW-1:0]];
          end
        end
        pal_pkg::OP_LOCATE: begin
          if (match == '0) begin
            out_res_nxt.status = pal_pkg::ST_NOT_FOUND;
          end else begin
            // matches go out from the scan state, one per beat
            out_valid_nxt = out_valid_r && !out_ready;
            out_res_nxt   = out_res_r;
            mask_nxt      = match;
            key_nxt       = req.item_value;
          end
        end
        default: begin
          out_res_nxt.status = pal_pkg::ST_BAD_POS;
        end
      endcase
      out_res_nxt.list_length = cnt_after[pal_pkg::POS_W-1:0];
    end else if ((state_r == pal_pkg::S_SCAN) && out_free) begin
      mask_nxt                   = mask_rest;
      out_valid_nxt              = 1'b1;
      out_res_nxt.status         = pal_pkg::ST_OK;
      out_res_nxt.found_position = pal_pkg::POS_W'(CMPW'(first_idx) + CMPW'(1));
      out_res_nxt.result_value   = key_r;
      out_res_nxt.list_length    = cnt_x[pal_pkg::POS_W-1:0];
      out_res_nxt.last           = (mask_rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pal_pkg::S_IDLE;
      count_r     <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_r[i] <= entries_nxt[i];
    end
    key_r     <= key_nxt;
    out_res_r <= out_res_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pal_pkg::S_SCAN) |-> (mask_r != '0))
    else $error("scan state with no pending match");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req.op == pal_pkg::OP_INSERT) && !ins_bad && !ins_full)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("successful insert did not grow the list");

  a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pal_pkg::S_SCAN) |-> !req_ready)
    else $error("request taken during a locate scan");
`endif

endmodule

### design/positional_array_list.sv
// positional_array_list: top level of the bounded positional list.
// Packs stream beats, holds the capacity limit register, joins pal_front and pal_back.
// Depends on pal_pkg, pal_front, pal_back.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+---------------------------------------
//   in_      | in  | in_tvalid/in_tready  | in_tdata: opcode, position, item_value
//   out_     | out | out_tvalid/out_tready| out_tdata: status..list_length; tlast
//   cfg_     | in  | cfg_valid/cfg_ready  | cfg_data: capacity_limit
//
// Insert, delete, bad requests and a locate with no match are answered with a
// single result beat registered in the accepting cycle; a locate with n matches
// goes through the accepting cycle, then the scan state with one result beat per
// match, so up to CAPACITY beats. A two-deep request queue sits in front of the back end.
// Reset (synchronous, rst_n low) empties the list and sets the limit to 10.
// Output stalls hold the result register; input keeps filling the queue meanwhile.
`timescale 1ns / 1ps

module positional_array_list #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] opcode, [6:2] position, [38:7] item_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [1:0] status, [6:2] found_position,
                                  // [38:7] result_value, [43:39] list_length
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // capacity_limit
);

  logic [4:0]       limit_r, limit_nxt;
  logic             req_valid, req_ready;
  pal_pkg::req_t    req;
  pal_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= pal_pkg::LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  pal_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_opcode    (in_tdata[1:0]),
    .in_position  (in_tdata[6:2]),
    .in_item_value(in_tdata[38:7]),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req)
  );

  pal_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (limit_r),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {4'b0000, res.list_length, res.result_value,
                      res.found_position, res.status};
  assign out_tlast = res.last;

endmodule

### verif/testbench.sv
// testbench: self-checking bench for positional_array_list (insert, delete, locate).
// Directed table, then random phases over several capacity limits, scored by a list predictor.
// Depends on pal_pkg and positional_array_list.
`timescale 1ns / 1ps

module testbench;

  localparam int LIST_CAP    = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    bit                is_cfg;
    pal_pkg::op_t      op;
    logic [4:0]        pos;
    logic [31:0]       val;     // limit for a cfg row
    bit                typed;
    pal_pkg::status_t  st;
    logic [31:0]       rval;
    logic [4:0]        len;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  // predictor state
  logic [31:0]      slots [LIST_CAP];
  int               list_cnt;
  int               cap_limit;
  pal_pkg::result_t step_out [$];
  pal_pkg::result_t pending_results [$];

  int          errors;
  int          cycles;
  bit          in_steady;
  bit          out_steady;

  logic [31:0] value_pool [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
  int          phase_limits [7] = '{16, 1, 16, 0, 7, 12, 16};

  row_t directed_rows [25] = '{
    '{0, pal_pkg::OP_LOCATE, 5'd0,  32'h0,         1, pal_pkg::ST_NOT_FOUND, 32'h0, 5'd0},
    '{0, pal_pkg::OP_DELETE, 5'd1,  32'h0,         1, pal_pkg::ST_BAD_POS,   32'h0, 5'd0},
    '{0, pal_pkg::OP_INSERT, 5'd0,  32'h1,         1, pal_pkg::ST_BAD_POS,   32'h0, 5'd0},
    '{0, pal_pkg::OP_INSERT, 5'd2,  32'h1,         1, pal_pkg::ST_BAD_POS,   32'h0, 5'd0},
    '{0, pal_pkg::OP_INSERT, 5'd1,  32'h8000_0000, 1, pal_pkg::ST_OK,        32'h0, 5'd1},
    '{0, pal_pkg::OP_INSERT, 5'd2,  32'h7FFF_FFFF, 1, pal_pkg::ST_OK,        32'h0, 5'd2},
    '{0, pal_pkg::OP_INSERT, 5'd1,  32'hFFFF_FFFF, 1, pal_pkg::ST_OK,        32'h0, 5'd3},
    '{0, pal_pkg::OP_INSERT, 5'd2,  32'h7FFF_FFFF, 1, pal_pkg::ST_OK,        32'h0, 5'd4},
    '{0, pal_pkg::OP_LOCATE, 5'd0,  32'h7FFF_FFFF, 0, pal_pkg::ST_OK,        32'h0, 5'd0},
    '{0, pal_pkg::OP_LOCATE, 5'd31, 32'h0,         1, pal_pkg::ST_NOT_FOUND, 32'h0, 5'd4},
    '{0, pal_pkg::OP_UNUSED, 5'd1,  32'h5,         1, pal_pkg::ST_BAD_POS,   32'h0, 5'd4},
    '{0, pal_pkg::OP_DELETE, 5'd5,  32'h0,         1, pal_pkg::ST_BAD_POS,   32'h0, 5'd4},
    '{0, pal_pkg::OP_DELETE, 5'd31, 32'h0,         1, pal_pkg::ST_BAD_POS,   32'h0, 5'd4},
    '{0, pal_pkg::OP_DELETE, 5'd1,  32'h0,         1, pal_pkg::ST_OK,  32'hFFFF_FFFF, 5'd3},
    '{0, pal_pkg::OP_INSERT, 5'd4,  32'h1234_5678, 0, pal_pkg::ST_OK,        32'h0, 5'd0},
    '{0, pal_pkg::OP_DELETE, 5'd4,  32'h0,         0, pal_pkg::ST_OK,        32'h0, 5'd0},
    '{1, pal_pkg::OP_INSERT, 5'd0,  32'd0,         0, pal_pkg::ST_OK,        32'h0, 5'd0},
    '{0, pal_pkg::OP_INSERT, 5'd1,  32'h9,         1, pal_pkg::ST_FULL,      32'h0, 5'd3},
    '{0, pal_pkg::OP_INSERT, 5'd0,  32'h9,         1, pal_pkg::ST_BAD_POS,   32'h0, 5'd3},
    '{0, pal_pkg::OP_LOCATE, 5'd16, 32'h8000_0000, 0, pal_pkg::ST_OK,        32'h0, 5'd0},
    '{0, pal_pkg::OP_DELETE, 5'd3,  32'h0,         0, pal_pkg::ST_OK,        32'h0, 5'd0},
    '{1, pal_pkg::OP_INSERT, 5'd0,  32'd3,         0, pal_pkg::ST_OK,        32'h0, 5'd0},
    '{0, pal_pkg::OP_INSERT, 5'd3,  32'h0,         0, pal_pkg::ST_OK,        32'h0, 5'd0},
    '{0, pal_pkg::OP_INSERT, 5'd1,  32'h0,         0, pal_pkg::ST_OK,        32'h0, 5'd0},
    '{0, pal_pkg::OP_UNUSED, 5'd16, 32'hFFFF_FFFF, 1, pal_pkg::ST_BAD_POS,   32'h0, 5'd3}
  };

  positional_array_list i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Works out the results of one request and updates the list copy.
  function automatic void predict_list_op(pal_pkg::op_t op, logic [4:0] pos,
                                          logic [31:0] val);
    int               lim;
    pal_pkg::result_t r;
    step_out.delete();
    lim = (cap_limit < LIST_CAP) ? cap_limit : LIST_CAP;
    r = '{status: pal_pkg::ST_BAD_POS, found_position: '0, result_value: '0,
          list_length: '0, last: 1'b1};
    case (op)
      pal_pkg::OP_INSERT: begin
        if (pos >= 1 && pos <= list_cnt + 1) begin
          if (list_cnt >= lim) begin
            r.status = pal_pkg::ST_FULL;
          end else begin
            for (int j = list_cnt; j >= pos; j--) slots[j] = slots[j-1];
            slots[pos-1] = val;
            list_cnt++;
            r.status = pal_pkg::ST_OK;
          end
        end
      end
      pal_pkg::OP_DELETE: begin
        if (pos >= 1 && pos <= list_cnt) begin
          r.result_value = slots[pos-1];
          for (int j = pos; j < list_cnt; j++) slots[j-1] = slots[j];
          list_cnt--;
          r.status = pal_pkg::ST_OK;
        end
      end
      pal_pkg::OP_LOCATE: begin
        for (int j = 0; j < list_cnt; j++) begin
          if (slots[j] == val)
            step_out.push_back('{status: pal_pkg::ST_OK, found_position: 5'(j + 1),
                                 result_value: val, list_length: 5'(list_cnt),
                                 last: 1'b0});
        end
        if (step_out.size() == 0) r.status = pal_pkg::ST_NOT_FOUND;
        else step_out[step_out.size()-1].last = 1'b1;
      end
      default: ;
    endcase
    r.list_length = 5'(list_cnt);
    if (step_out.size() == 0) step_out.push_back(r);
  endfunction

  task automatic send_request(pal_pkg::op_t op, logic [4:0] pos, logic [31:0] val,
                              bit typed, pal_pkg::result_t typed_res);
    int gap;
    if ($urandom_range(0, 23) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, pos, op};
    do @(posedge clk); while (!in_tready);
    predict_list_op(op, pos, val);
    if (typed) pending_results.push_back(typed_res);
    else foreach (step_out[k]) pending_results.push_back(step_out[k]);
  endtask

  // Limit writes only go in once the list has gone quiet.
  task automatic write_limit(int limit);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 5'(limit);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_limit = limit;
  endtask

  // result sink with random back-pressure
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 23) == 0) out_steady = !out_steady;
      gap = out_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    pal_pkg::result_t want;
    pal_pkg::result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status         = pal_pkg::status_t'(out_tdata[1:0]);
      got.found_position = out_tdata[6:2];
      got.result_value   = out_tdata[38:7];
      got.list_length    = out_tdata[43:39];
      got.last           = out_tlast;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: status %0d pos %0d value %h len %0d last %0b",
                   got.status, got.found_position, got.result_value, got.list_length,
                   got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.found_position !== want.found_position ||
            got.result_value !== want.result_value || got.list_length !== want.list_length ||
            got.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp st %0d pos %0d val %h len %0d last %0b",
                      " | got st %0d pos %0d val %h len %0d last %0b"},
                     want.status, want.found_position, want.result_value, want.list_length,
                     want.last, got.status, got.found_position, got.result_value,
                     got.list_length, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    pal_pkg::result_t typed_res;
    pal_pkg::op_t     op;
    int               pick;
    int               lim;
    logic [4:0]       pos;
    logic [31:0]      val;

    list_cnt   = 0;
    cap_limit  = 10;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_limit(int'(directed_rows[i].val));
      end else begin
        typed_res = '{status: directed_rows[i].st, found_position: '0,
                      result_value: directed_rows[i].rval, list_length: directed_rows[i].len,
                      last: 1'b1};
        send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                     directed_rows[i].typed, typed_res);
      end
    end

    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      for (int n = 0; n < 36; n++) begin
        lim  = (cap_limit < LIST_CAP) ? cap_limit : LIST_CAP;
        pick = $urandom_range(0, 99);
        // lean on inserts while there is room so the list actually fills up
        if (pick < 3) op = pal_pkg::OP_UNUSED;
        else if (pick < ((list_cnt < lim) ? 60 : 40)) op = pal_pkg::OP_INSERT;
        else if (pick < 75) op = pal_pkg::OP_DELETE;
        else op = pal_pkg::OP_LOCATE;
        if ($urandom_range(0, 9) == 0) pos = 5'($urandom_range(0, 31));
        else if (op == pal_pkg::OP_INSERT) pos = 5'($urandom_range(1, list_cnt + 1));
        else if (list_cnt > 0) pos = 5'($urandom_range(1, list_cnt));
        else pos = 5'd1;
        if ($urandom_range(0, 3) == 0) val = $urandom;
        else val = value_pool[$urandom_range(0, 3)];
        send_request(op, pos, val, 1'b0, typed_res);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
